// File: hdl/dual_tap_feedback_comb_assert.svh
// Assertion macros for the dual-tap feedback comb project.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef DUAL_TAP_FEEDBACK_COMB_ASSERT_SVH
`define DUAL_TAP_FEEDBACK_COMB_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define DTFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that must be followed by a consequent in the next cycle.
`define DTFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dtfc_pkg.sv
// Shared types and constants of the dual-tap feedback comb filter.
// Depends on nothing; the top level, registers, datapath and checker import it.
package dtfc_pkg;

    // Field widths of the stream and register payloads.
    localparam int SAMPLE_W      = 16;
    localparam int GAIN_W        = 16;
    localparam int OUT_W         = 24;
    localparam int DELAY_FIELD_W = 13;
    localparam int FRAC_SHIFT    = 14;
    localparam int PROD_W        = OUT_W + GAIN_W;
    localparam int TERM_W        = PROD_W - FRAC_SHIFT;
    localparam int SUM_W         = TERM_W + 2;

    // APB port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Saturation rails of the output.
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_DELAY_ONE = 2'd0;
    localparam logic [1:0] REG_GAIN_ONE  = 2'd1;
    localparam logic [1:0] REG_DELAY_TWO = 2'd2;
    localparam logic [1:0] REG_GAIN_TWO  = 2'd3;

    // Per-tap control decided when a sample is accepted.
    typedef struct packed {
        logic enable;   // enough samples have passed since the stream start
        logic bypass;   // delay of one: use the previous output directly
    } tap_ctl_t;

endpackage

// File: hdl/dual_tap_feedback_comb.sv
// An accepted sample waits in the compute stage and moves on once the output register frees.
// Throughput: one sample per cycle unless the output stalls; both history taps come from RAM read ports.
// A delay of one is served from the last output register, bypassing the RAM.
// Reset is asynchronous and active low; it clears pointers, counts and valid flags and resets the configuration.
// History memory is not cleared; tap gating never uses an entry not yet written.
module dual_tap_feedback_comb import dtfc_pkg::*; #(
    parameter int MAX_DELAY = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
    input  logic                  s_tuser,   // [0] stream_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // [23:0] sample_out
    output logic                  m_tuser    // [0] clipped
);

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int CW = $clog2(MAX_DELAY + 1);

    logic [CW-1:0]              delay_one;
    logic [CW-1:0]              delay_two;
    logic signed [GAIN_W-1:0]   gain_one;
    logic signed [GAIN_W-1:0]   gain_two;

    logic [AW-1:0]              wp_reg;
    logic [AW-1:0]              wp_next;
    logic [CW-1:0]              seen_reg;
    logic [CW-1:0]              seen_next;
    logic [CW-1:0]              index;

    logic                       comp_valid_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [AW-1:0]              waddr_reg;
    tap_ctl_t                   tap_one_reg;
    tap_ctl_t                   tap_two_reg;
    tap_ctl_t                   tap_one_next;
    tap_ctl_t                   tap_two_next;
    logic signed [OUT_W-1:0]    last_y_reg;

    logic                       out_valid_reg;
    logic [OUT_W-1:0]           out_data_reg;
    logic                       out_clip_reg;

    logic                       accept;
    logic                       comp_advance;
    logic [CW:0]                raw_one;
    logic [CW:0]                raw_two;
    logic [CW:0]                wrap_one;
    logic [CW:0]                wrap_two;
    logic [AW-1:0]              raddr_one;
    logic [AW-1:0]              raddr_two;
    logic [OUT_W-1:0]           hist_one;
    logic [OUT_W-1:0]           hist_two;
    logic signed [OUT_W-1:0]    y;
    logic                       clip;

    // Configuration registers.
    dtfc_regs #(
        .MAX_DELAY (MAX_DELAY)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .delay_one (delay_one),
        .delay_two (delay_two),
        .gain_one  (gain_one),
        .gain_two  (gain_two)
    );

    assign pready = 1'b1;

    // Stage handshakes: the compute stage moves on when the output register frees.
    assign comp_advance = comp_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready     = !comp_valid_reg || !out_valid_reg || m_tready;
    assign accept       = s_tvalid && s_tready;

    // Sample index since the stream start, and tap gating from it.
    assign index = s_tuser ? '0 : seen_reg;

    always_comb
    begin
        tap_one_next.enable = (index >= delay_one);
        tap_one_next.bypass = (delay_one == CW'(1));
        tap_two_next.enable = (index >= delay_two);
        tap_two_next.bypass = (delay_two == CW'(1));
    end

    assign seen_next = (index < CW'(MAX_DELAY)) ? index + CW'(1) : CW'(MAX_DELAY);
    assign wp_next   = (wp_reg == AW'(MAX_DELAY - 1)) ? '0 : wp_reg + AW'(1);

    // Circular read addresses of the two taps.
    assign raw_one  = (CW+1)'(wp_reg) + (CW+1)'(MAX_DELAY) - (CW+1)'(delay_one);
    assign raw_two  = (CW+1)'(wp_reg) + (CW+1)'(MAX_DELAY) - (CW+1)'(delay_two);
    assign wrap_one = (raw_one >= (CW+1)'(MAX_DELAY)) ? raw_one - (CW+1)'(MAX_DELAY)
                                                      : raw_one;
    assign wrap_two = (raw_two >= (CW+1)'(MAX_DELAY)) ? raw_two - (CW+1)'(MAX_DELAY)
                                                      : raw_two;
    assign raddr_one = wrap_one[AW-1:0];
    assign raddr_two = wrap_two[AW-1:0];

    // Output history.
    dtfc_ram #(
        .WIDTH (OUT_W),
        .DEPTH (MAX_DELAY)
    ) u_history (
        .clk     (clk),
        .we      (comp_advance),
        .waddr   (waddr_reg),
        .wdata   (y),
        .re      (accept),
        .raddr_a (raddr_one),
        .raddr_b (raddr_two),
        .rdata_a (hist_one),
        .rdata_b (hist_two)
    );

    // Tap arithmetic.
    dtfc_datapath u_datapath (
        .x        (x_reg),
        .gain_one (gain_one),
        .gain_two (gain_two),
        .tap_one  (tap_one_reg),
        .tap_two  (tap_two_reg),
        .hist_one (hist_one),
        .hist_two (hist_two),
        .last_y   (last_y_reg),
        .y        (y),
        .clip     (clip)
    );

    // Control state: pointers and stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            seen_reg       <= '0;
            comp_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg   <= wp_next;
                seen_reg <= seen_next;
            end
            if (accept)
            begin
                comp_valid_reg <= 1'b1;
            end
            else if (comp_advance)
            begin
                comp_valid_reg <= 1'b0;
            end
            if (comp_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input stage payload, captured with the transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg       <= s_tdata;
            waddr_reg   <= wp_reg;
            tap_one_reg <= tap_one_next;
            tap_two_reg <= tap_two_next;
        end
    end

    // Result register and the last output kept for a delay of one.
    always_ff @(posedge clk)
    begin
        if (comp_advance)
        begin
            out_data_reg <= y;
            out_clip_reg <= clip;
            last_y_reg   <= y;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_clip_reg;

endmodule

// File: hdl/dtfc_ram.sv
// Generic simple dual-port RAM: one write port and two registered read ports.
// Uses no package; the filter history is built from it.
module dtfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports; the data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: hdl/dtfc_regs.sv
// APB configuration registers of the comb filter: two delays and two gains.
// Depends on dtfc_pkg for widths and register indexes.
module dtfc_regs import dtfc_pkg::*; #(
    parameter int MAX_DELAY = 4096,
    localparam int CW = $clog2(MAX_DELAY + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic [CW-1:0]            delay_one,
    output logic [CW-1:0]            delay_two,
    output logic signed [GAIN_W-1:0] gain_one,
    output logic signed [GAIN_W-1:0] gain_two
);

    logic [CW-1:0]            delay_one_reg;
    logic [CW-1:0]            delay_two_reg;
    logic signed [GAIN_W-1:0] gain_one_reg;
    logic signed [GAIN_W-1:0] gain_two_reg;
    logic                     wr_en;
    logic [1:0]               reg_idx;
    logic [DELAY_FIELD_W-1:0] delay_field;
    logic [CW-1:0]            delay_clamped;

    assign wr_en       = psel && penable && pwrite;
    assign reg_idx     = paddr[3:2];
    assign delay_field = pwdata[DELAY_FIELD_W-1:0];

    // A zero delay acts as one; a delay beyond the history acts as its length.
    always_comb
    begin
        if (delay_field == '0)
        begin
            delay_clamped = CW'(1);
        end
        else if (32'(delay_field) > 32'(MAX_DELAY))
        begin
            delay_clamped = CW'(MAX_DELAY);
        end
        else
        begin
            delay_clamped = CW'(delay_field);
        end
    end

    // Register writes at the access phase of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_one_reg <= CW'(1);
            delay_two_reg <= CW'(1);
            gain_one_reg  <= '0;
            gain_two_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DELAY_ONE: delay_one_reg <= delay_clamped;
                REG_GAIN_ONE:  gain_one_reg  <= pwdata[GAIN_W-1:0];
                REG_DELAY_TWO: delay_two_reg <= delay_clamped;
                REG_GAIN_TWO:  gain_two_reg  <= pwdata[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read-back decoder.
    always_comb
    begin
        unique case (reg_idx)
            REG_DELAY_ONE: prdata = APB_DATA_W'(delay_one_reg);
            REG_GAIN_ONE:  prdata = APB_DATA_W'($unsigned(gain_one_reg));
            REG_DELAY_TWO: prdata = APB_DATA_W'(delay_two_reg);
            REG_GAIN_TWO:  prdata = APB_DATA_W'($unsigned(gain_two_reg));
            default:       prdata = '0;
        endcase
    end

    assign delay_one = delay_one_reg;
    assign delay_two = delay_two_reg;
    assign gain_one  = gain_one_reg;
    assign gain_two  = gain_two_reg;

endmodule

// File: hdl/dtfc_datapath.sv
// Feedback arithmetic of the comb filter: two tap products, sum and saturation.
// Depends on dtfc_pkg for widths, rails and the tap control struct.
module dtfc_datapath import dtfc_pkg::*; (
    input  logic signed [SAMPLE_W-1:0] x,
    input  logic signed [GAIN_W-1:0]   gain_one,
    input  logic signed [GAIN_W-1:0]   gain_two,
    input  tap_ctl_t                   tap_one,
    input  tap_ctl_t                   tap_two,
    input  logic signed [OUT_W-1:0]    hist_one,
    input  logic signed [OUT_W-1:0]    hist_two,
    input  logic signed [OUT_W-1:0]    last_y,
    output logic signed [OUT_W-1:0]    y,
    output logic                       clip
);

    logic signed [OUT_W-1:0]  tapv_one;
    logic signed [OUT_W-1:0]  tapv_two;
    logic signed [PROD_W-1:0] prod_one;
    logic signed [PROD_W-1:0] prod_two;
    logic signed [TERM_W-1:0] term_one;
    logic signed [TERM_W-1:0] term_two;
    logic signed [SUM_W-1:0]  sum;

    // A delay of one takes the previous output, which may not be in memory yet.
    assign tapv_one = tap_one.bypass ? last_y : hist_one;
    assign tapv_two = tap_two.bypass ? last_y : hist_two;

    // Exact products, floored by dropping the fraction bits.
    assign prod_one = PROD_W'(tapv_one) * PROD_W'(gain_one);
    assign prod_two = PROD_W'(tapv_two) * PROD_W'(gain_two);

    assign term_one = tap_one.enable ? prod_one[PROD_W-1:FRAC_SHIFT] : '0;
    assign term_two = tap_two.enable ? prod_two[PROD_W-1:FRAC_SHIFT] : '0;

    // Full-width sum, then one saturation to the output width.
    assign sum = SUM_W'(x) + SUM_W'(term_one) + SUM_W'(term_two);

    always_comb
    begin
        if (sum > SUM_W'(OUT_MAX))
        begin
            y    = OUT_MAX;
            clip = 1'b1;
        end
        else if (sum < SUM_W'(OUT_MIN))
        begin
            y    = OUT_MIN;
            clip = 1'b1;
        end
        else
        begin
            y    = sum[OUT_W-1:0];
            clip = 1'b0;
        end
    end

endmodule

// File: hdl/dtfc_checker.sv
// Port-level checker of the dual-tap feedback comb, bound to the top level.
// Depends on dtfc_pkg and the assertion macros header.
`include "dual_tap_feedback_comb_assert.svh"

module dtfc_checker import dtfc_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pready,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_W-1:0]      m_tdata,
    input logic                  m_tuser
);

    logic on_rail;

    // The result sits on one of the two saturation rails.
    assign on_rail = (m_tdata == OUT_MAX) || (m_tdata == OUT_MIN);

    // An offered result stays offered until its transaction completes.
    `DTFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped")

    // A clipped result sits on one of the two saturation rails.
    `DTFC_ASSERT(a_clip_rail, !(m_tvalid && m_tuser) || on_rail, "clip off rail")

    // With the result register empty the block always takes a sample.
    `DTFC_ASSERT(a_ready_when_empty, m_tvalid || s_tready, "input blocked while output empty")

    // The configuration port never inserts wait states.
    `DTFC_ASSERT(a_pready_high, pready, "pready low")

endmodule

bind dual_tap_feedback_comb dtfc_checker u_dtfc_checker (.*);
